### sv/session_range_breakout_trader_macros.svh
// Assertion macros shared by the session range breakout trader modules.
`ifndef SESSION_RANGE_BREAKOUT_TRADER_MACROS_SVH
`define SESSION_RANGE_BREAKOUT_TRADER_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define SRBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srbt: implication check failed");

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define SRBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srbt: next-cycle check failed");

`endif

### sv/srbt_pkg.sv
// Shared types and constants of the session range breakout trader.
package srbt_pkg;

  // Fixed field widths
  localparam int HOUR_W       = 5;
  localparam int BUF_W        = 7;
  localparam int TENTHS_W     = 7;
  localparam int LIMIT_W      = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 14;
  localparam int PNL_W        = 21;
  localparam int CAUSE_W      = 2;

  // Return scaling: hundredths of a bp per unit of relative move
  localparam int SCALE_W      = 20;
  localparam logic [SCALE_W-1:0] PNL_SCALE = 20'd1000000;
  localparam logic [PNL_W-1:0]   PNL_LIMIT = 21'd1000000;
  // Quotient bits produced by the divider (enough to cover the limit)
  localparam int QUO_W        = 21;

  // Range and entry constants
  localparam logic [6:0]  HUNDRED   = 7'd100;
  localparam logic [13:0] BP_SCALE  = 14'd10000;

  // Register reset values
  localparam logic [BUF_W-1:0]    BUFFER_PERCENT_RST    = 7'd20;
  localparam logic [TENTHS_W-1:0] TARGET_TENTHS_RST     = 7'd20;
  localparam logic [LIMIT_W-1:0]  COMPRESS_LIMIT_RST    = 14'd40;
  localparam logic [HOUR_W-1:0]   RANGE_END_HOUR_RST    = 5'd7;
  localparam logic [HOUR_W-1:0]   ENTRY_END_HOUR_RST    = 5'd12;
  localparam logic [HOUR_W-1:0]   EXIT_HOUR_RST         = 5'd21;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_PERCENT    = 3'd0,
    CFG_TARGET_TENTHS     = 3'd1,
    CFG_COMPRESS_LIMIT_BP = 3'd2,
    CFG_RANGE_END_HOUR    = 3'd3,
    CFG_ENTRY_END_HOUR    = 3'd4,
    CFG_EXIT_HOUR         = 3'd5
  } srbt_cfg_idx_e;

  // Exit causes
  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_STOP   = 2'd0,
    CAUSE_TARGET = 2'd1,
    CAUSE_TIME   = 2'd2
  } srbt_cause_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_ENTRY,
    S_EXIT,
    S_DIVCHK,
    S_DIV,
    S_DONE
  } srbt_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // register the bar, apply the new-day clear
    logic range_upd;  // fold the mid into the range
    logic rng_calc;   // range width and x100 terms
    logic mul;        // buffer, compression and target products
    logic entry;      // breakout decision and position open
    logic exit_eval;  // stop/target/time test, difference
    logic scale;      // difference times the return scale
    logic div_init;   // saturation check and divider load
    logic div_step;   // one quotient bit
    logic out_load;   // fill the result register
  } srbt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bar_ok;
    logic in_pos;
    logic range_hour;
    logic may_enter;
    logic exit_hit;
    logic div_sat;
    logic div_last;
    logic out_free;
  } srbt_sts_t;

endpackage

### sv/srbt_if.sv
// Handshake channels of the trader: bar input and trade result output.
interface srbt_bar_if #(
  parameter int PRICE_BITS = 24
);
  logic                            valid;
  logic                            ready;
  logic                            new_day;
  logic [srbt_pkg::HOUR_W-1:0]     hour;
  logic [PRICE_BITS-1:0]           bid_price;
  logic [PRICE_BITS-1:0]           ask_price;

  modport source (output valid, new_day, hour, bid_price, ask_price, input ready);
  modport sink (input valid, new_day, hour, bid_price, ask_price, output ready);
endinterface

interface srbt_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [srbt_pkg::PNL_W-1:0] pnl_centi_bp;
  logic                              went_long;
  logic [srbt_pkg::CAUSE_W-1:0]      exit_cause;

  modport source (output valid, pnl_centi_bp, went_long, exit_cause, input ready);
  modport sink (input valid, pnl_centi_bp, went_long, exit_cause, output ready);
endinterface

### sv/srbt_ctrl.sv
// Controller state machine: sequences the trader datapath for each bar.
`include "session_range_breakout_trader_macros.svh"

module srbt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                bar_valid_i,
  output logic                bar_ready_o,
  input  srbt_pkg::srbt_sts_t sts_i,
  output srbt_pkg::srbt_cmd_t cmd_o
);

  srbt_pkg::srbt_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srbt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srbt_pkg::S_IDLE: begin
        if (bar_valid_i) state_d = srbt_pkg::S_EVAL;
      end
      srbt_pkg::S_EVAL: begin
        if (!sts_i.bar_ok) begin
          state_d = srbt_pkg::S_IDLE;
        end else if (sts_i.in_pos) begin
          state_d = srbt_pkg::S_EXIT;
        end else if (sts_i.range_hour) begin
          state_d = srbt_pkg::S_IDLE;
        end else if (sts_i.may_enter) begin
          state_d = srbt_pkg::S_MUL;
        end else begin
          state_d = srbt_pkg::S_IDLE;
        end
      end
      srbt_pkg::S_MUL:   state_d = srbt_pkg::S_ENTRY;
      srbt_pkg::S_ENTRY: state_d = srbt_pkg::S_IDLE;
      srbt_pkg::S_EXIT: begin
        state_d = sts_i.exit_hit ? srbt_pkg::S_DIVCHK : srbt_pkg::S_IDLE;
      end
      srbt_pkg::S_DIVCHK: begin
        state_d = sts_i.div_sat ? srbt_pkg::S_DONE : srbt_pkg::S_DIV;
      end
      srbt_pkg::S_DIV: begin
        if (sts_i.div_last) state_d = srbt_pkg::S_DONE;
      end
      srbt_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = srbt_pkg::S_IDLE;
      end
      default: state_d = srbt_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    bar_ready_o = 1'b0;
    case (state_q)
      srbt_pkg::S_IDLE: begin
        bar_ready_o   = 1'b1;
        cmd_o.capture = bar_valid_i;
      end
      srbt_pkg::S_EVAL: begin
        if (sts_i.bar_ok) begin
          if (sts_i.in_pos) begin
            cmd_o.exit_eval = 1'b1;
          end else if (sts_i.range_hour) begin
            cmd_o.range_upd = 1'b1;
          end else if (sts_i.may_enter) begin
            cmd_o.rng_calc = 1'b1;
          end
        end
      end
      srbt_pkg::S_MUL:    cmd_o.mul = 1'b1;
      srbt_pkg::S_ENTRY:  cmd_o.entry = 1'b1;
      srbt_pkg::S_EXIT:   cmd_o.scale = sts_i.exit_hit;
      srbt_pkg::S_DIVCHK: cmd_o.div_init = 1'b1;
      srbt_pkg::S_DIV:    cmd_o.div_step = 1'b1;
      srbt_pkg::S_DONE:   cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  // A loaded result always hands control back for the next bar
  `SRBT_ASSERT_NXT(a_load_then_idle, cmd_o.out_load, state_q == srbt_pkg::S_IDLE)
  // The last quotient bit leads straight to the result stage
  `SRBT_ASSERT_NXT(a_div_last_done, cmd_o.div_step && sts_i.div_last,
                   state_q == srbt_pkg::S_DONE)

endmodule

### sv/srbt_dp.sv
// Datapath: configuration, day state, range, entry products, exit test and divider.
`include "session_range_breakout_trader_macros.svh"

module srbt_dp #(
  parameter int PRICE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [srbt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [srbt_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // bar fields
  input  logic                                 new_day_i,
  input  logic [srbt_pkg::HOUR_W-1:0]          hour_i,
  input  logic [PRICE_BITS-1:0]                bid_price_i,
  input  logic [PRICE_BITS-1:0]                ask_price_i,
  // result register
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic signed [srbt_pkg::PNL_W-1:0]    pnl_centi_bp_o,
  output logic                                 went_long_o,
  output logic [srbt_pkg::CAUSE_W-1:0]         exit_cause_o,
  // control
  input  srbt_pkg::srbt_cmd_t                  cmd_i,
  output srbt_pkg::srbt_sts_t                  sts_o
);

  localparam int D_W   = PRICE_BITS + 1;          // doubled price
  localparam int H_W   = D_W + 7;                 // doubled price times up to 127
  localparam int S_W   = H_W + 1;                 // sum of two such terms
  localparam int K_W   = D_W + srbt_pkg::LIMIT_W; // compression products
  localparam int X_W   = PRICE_BITS + 5;          // price times 20
  localparam int T_W   = PRICE_BITS + 10;         // signed target level
  localparam int PR_W  = PRICE_BITS + srbt_pkg::SCALE_W;
  localparam int HI_W  = PR_W - srbt_pkg::QUO_W;
  localparam int CNT_W = $clog2(srbt_pkg::QUO_W);
  localparam int PW    = srbt_pkg::PNL_W;

  // Configuration registers
  logic [srbt_pkg::BUF_W-1:0]    buf_pct_q;
  logic [srbt_pkg::TENTHS_W-1:0] tgt_tenths_q;
  logic [srbt_pkg::LIMIT_W-1:0]  limit_bp_q;
  logic [srbt_pkg::HOUR_W-1:0]   range_end_q, entry_end_q, exit_hour_q;

  // Day state
  logic [D_W-1:0]        range_hi_q, range_lo_q;
  logic                  range_seen_q, in_pos_q, pos_long_q, day_done_q;
  logic [PRICE_BITS-1:0] entry_q;
  logic [D_W-1:0]        stop_q;
  logic signed [T_W-1:0] target_q;

  // Registered bar
  logic [srbt_pkg::HOUR_W-1:0] hour_q;
  logic [PRICE_BITS-1:0]       bid_q, ask_q;
  logic [D_W-1:0]              mid2_q;
  logic                        bar_ok_q;

  // Entry products
  logic [D_W-1:0] rng2_q;
  logic [H_W-1:0] m100_q, hi100_q, lo100_q, buf_q, ttr_q;
  logic [K_W-1:0] rngk_q, limlo_q;

  // Exit and divider
  logic                          ex_q, neg_q, sat_q;
  logic [srbt_pkg::CAUSE_W-1:0]  cause_q;
  logic [PRICE_BITS-1:0]         mag_q, rem_q;
  logic [PR_W-1:0]               prod_q;
  logic [srbt_pkg::QUO_W-1:0]    low_q, quo_q;
  logic [CNT_W-1:0]              cnt_q;

  // Result register
  logic                          res_valid_q;
  logic signed [PW-1:0]          res_pnl_q;
  logic                          res_long_q;
  logic [srbt_pkg::CAUSE_W-1:0]  res_cause_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_pct_q    <= srbt_pkg::BUFFER_PERCENT_RST;
      tgt_tenths_q <= srbt_pkg::TARGET_TENTHS_RST;
      limit_bp_q   <= srbt_pkg::COMPRESS_LIMIT_RST;
      range_end_q  <= srbt_pkg::RANGE_END_HOUR_RST;
      entry_end_q  <= srbt_pkg::ENTRY_END_HOUR_RST;
      exit_hour_q  <= srbt_pkg::EXIT_HOUR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        srbt_pkg::CFG_BUFFER_PERCENT:    buf_pct_q    <= cfg_data_i[srbt_pkg::BUF_W-1:0];
        srbt_pkg::CFG_TARGET_TENTHS:     tgt_tenths_q <= cfg_data_i[srbt_pkg::TENTHS_W-1:0];
        srbt_pkg::CFG_COMPRESS_LIMIT_BP: limit_bp_q   <= cfg_data_i[srbt_pkg::LIMIT_W-1:0];
        srbt_pkg::CFG_RANGE_END_HOUR:    range_end_q  <= cfg_data_i[srbt_pkg::HOUR_W-1:0];
        srbt_pkg::CFG_ENTRY_END_HOUR:    entry_end_q  <= cfg_data_i[srbt_pkg::HOUR_W-1:0];
        srbt_pkg::CFG_EXIT_HOUR:         exit_hour_q  <= cfg_data_i[srbt_pkg::HOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Bar capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hour_q   <= hour_i;
      bid_q    <= bid_price_i;
      ask_q    <= ask_price_i;
      mid2_q   <= D_W'(bid_price_i) + D_W'(ask_price_i);
      bar_ok_q <= ask_price_i > bid_price_i;
    end
  end

  // Exit test on the registered bar
  logic [X_W-1:0]        bid20, ask20;
  logic                  stop_hit, tgt_hit, time_hit, exit_now;
  logic [srbt_pkg::CAUSE_W-1:0] cause_now;
  logic [PRICE_BITS-1:0] dif_a, dif_b;

  always_comb begin
    bid20    = X_W'({bid_q, 4'b0}) + X_W'({bid_q, 2'b0});
    ask20    = X_W'({ask_q, 4'b0}) + X_W'({ask_q, 2'b0});
    time_hit = hour_q >= exit_hour_q;
    if (pos_long_q) begin
      stop_hit = {bid_q, 1'b0} <= stop_q;
      tgt_hit  = $signed(T_W'(bid20)) >= target_q;
      dif_a    = bid_q;
      dif_b    = entry_q;
    end else begin
      stop_hit = {ask_q, 1'b0} >= stop_q;
      tgt_hit  = $signed(T_W'(ask20)) <= target_q;
      dif_a    = entry_q;
      dif_b    = ask_q;
    end
    exit_now  = stop_hit || tgt_hit || time_hit;
    if (stop_hit) begin
      cause_now = srbt_pkg::CAUSE_STOP;
    end else if (tgt_hit) begin
      cause_now = srbt_pkg::CAUSE_TARGET;
    end else begin
      cause_now = srbt_pkg::CAUSE_TIME;
    end
  end

  // Breakout decision from the registered products
  logic [S_W-1:0]        up_bound, dn_sum;
  logic                  go_long, go_short, compress_ok;
  logic signed [T_W-1:0] tgt_long, tgt_short;

  always_comb begin
    up_bound    = S_W'(hi100_q) + S_W'(buf_q);
    dn_sum      = S_W'(m100_q) + S_W'(buf_q);
    compress_ok = !(rngk_q > limlo_q);
    go_long     = compress_ok && (S_W'(m100_q) > up_bound);
    go_short    = compress_ok && !go_long && (dn_sum < S_W'(lo100_q));
    tgt_long    = $signed(T_W'(ask20)) + $signed(T_W'(ttr_q));
    tgt_short   = $signed(T_W'(bid20)) - $signed(T_W'(ttr_q));
  end

  // Day state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_hi_q   <= '0;
      range_lo_q   <= '1;
      range_seen_q <= 1'b0;
      in_pos_q     <= 1'b0;
      pos_long_q   <= 1'b0;
      day_done_q   <= 1'b0;
      entry_q      <= '0;
      stop_q       <= '0;
      target_q     <= '0;
    end else if (cmd_i.capture && new_day_i) begin
      range_hi_q   <= '0;
      range_lo_q   <= '1;
      range_seen_q <= 1'b0;
      in_pos_q     <= 1'b0;
      pos_long_q   <= 1'b0;
      day_done_q   <= 1'b0;
      entry_q      <= '0;
      stop_q       <= '0;
      target_q     <= '0;
    end else if (cmd_i.range_upd) begin
      if (mid2_q > range_hi_q) range_hi_q <= mid2_q;
      if (mid2_q < range_lo_q) range_lo_q <= mid2_q;
      range_seen_q <= 1'b1;
    end else if (cmd_i.exit_eval && exit_now) begin
      in_pos_q   <= 1'b0;
      day_done_q <= 1'b1;
    end else if (cmd_i.entry && go_long) begin
      in_pos_q   <= 1'b1;
      pos_long_q <= 1'b1;
      entry_q    <= ask_q;
      stop_q     <= range_lo_q;
      target_q   <= tgt_long;
    end else if (cmd_i.entry && go_short) begin
      in_pos_q   <= 1'b1;
      pos_long_q <= 1'b0;
      entry_q    <= bid_q;
      stop_q     <= range_hi_q;
      target_q   <= tgt_short;
    end
  end

  // Range width and x100 terms, then the products
  always_ff @(posedge clk_i) begin
    if (cmd_i.rng_calc) begin
      rng2_q  <= range_hi_q - range_lo_q;
      m100_q  <= H_W'(mid2_q) * H_W'(srbt_pkg::HUNDRED);
      hi100_q <= H_W'(range_hi_q) * H_W'(srbt_pkg::HUNDRED);
      lo100_q <= H_W'(range_lo_q) * H_W'(srbt_pkg::HUNDRED);
    end
    if (cmd_i.mul) begin
      buf_q   <= H_W'(rng2_q) * H_W'(buf_pct_q);
      ttr_q   <= H_W'(rng2_q) * H_W'(tgt_tenths_q);
      rngk_q  <= K_W'(rng2_q) * K_W'(srbt_pkg::BP_SCALE);
      limlo_q <= K_W'(limit_bp_q) * K_W'(range_lo_q);
    end
  end

  // Exit registration, scaling and the restoring divider
  logic [PRICE_BITS:0]   trial, trial_sub;
  logic                  trial_ge;
  logic [HI_W-1:0]       prod_hi;
  logic                  div_sat;

  always_comb begin
    prod_hi   = prod_q[PR_W-1:srbt_pkg::QUO_W];
    div_sat   = (mag_q == '0) || ({1'b0, prod_hi} >= entry_q);
    trial     = {rem_q, low_q[srbt_pkg::QUO_W-1]};
    trial_sub = trial - {1'b0, entry_q};
    trial_ge  = trial >= {1'b0, entry_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exit_eval) begin
      ex_q    <= exit_now;
      cause_q <= cause_now;
      neg_q   <= dif_a < dif_b;
      mag_q   <= (dif_a < dif_b) ? (dif_b - dif_a) : (dif_a - dif_b);
    end
    if (cmd_i.scale) begin
      prod_q <= PR_W'(mag_q) * PR_W'(srbt_pkg::PNL_SCALE);
    end
    if (cmd_i.div_init) begin
      sat_q <= div_sat;
      rem_q <= PRICE_BITS'(prod_hi);
      low_q <= prod_q[srbt_pkg::QUO_W-1:0];
      quo_q <= '0;
      cnt_q <= CNT_W'(srbt_pkg::QUO_W - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[PRICE_BITS-1:0] : trial[PRICE_BITS-1:0];
      low_q <= {low_q[srbt_pkg::QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[srbt_pkg::QUO_W-2:0], trial_ge};
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Clamp and sign the return
  logic [PW-1:0] mag_res;

  always_comb begin
    if (mag_q == '0) begin
      mag_res = '0;
    end else if (sat_q || (quo_q > srbt_pkg::PNL_LIMIT)) begin
      mag_res = srbt_pkg::PNL_LIMIT;
    end else begin
      mag_res = quo_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_pnl_q   <= neg_q ? $signed(~mag_res + PW'(1)) : $signed(mag_res);
      res_long_q  <= pos_long_q;
      res_cause_q <= cause_q;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign pnl_centi_bp_o = res_pnl_q;
  assign went_long_o    = res_long_q;
  assign exit_cause_o   = res_cause_q;

  // Status
  always_comb begin
    sts_o            = '0;
    sts_o.bar_ok     = bar_ok_q;
    sts_o.in_pos     = in_pos_q;
    sts_o.range_hour = hour_q < range_end_q;
    sts_o.may_enter  = !day_done_q && range_seen_q && (hour_q < entry_end_q) &&
                       (range_hi_q > range_lo_q);
    sts_o.exit_hit   = ex_q;
    sts_o.div_sat    = div_sat;
    sts_o.div_last   = cnt_q == '0;
    sts_o.out_free   = !res_valid_q || res_ready_i;
  end

  // A long's stop sits below twice its entry, a short's above
  `SRBT_ASSERT_IMP(a_long_stop_side, in_pos_q && pos_long_q, stop_q < {entry_q, 1'b0})
  `SRBT_ASSERT_IMP(a_short_stop_side, in_pos_q && !pos_long_q, stop_q > {entry_q, 1'b0})
  // Partial remainder stays below the divisor throughout the division
  `SRBT_ASSERT_IMP(a_rem_below_entry, cmd_i.div_step, rem_q < entry_q)

endmodule

### sv/session_range_breakout_trader.sv
// Top level of the session range breakout trader: controller plus datapath.
//
// Takes one minute bar per transaction on bar_i and returns at most one trade
// result per bar on result_o, when an open position closes. A bar that is
// ignored, builds the range or finds no setup ends after its evaluation. A bar
// that tests for an entry computes the range width, then the buffer, target
// and two compression products, then the decision. A bar that tests an open
// position and exits finds its return with a restoring divider that yields
// one of its 21 quotient bits per cycle. A return that saturates or is zero
// skips the divider. An exit bar holds its last state until the result
// register is free, so a stalled receiver also stalls the next bar. Registers
// are written through cfg_we_i/cfg_index_i/cfg_data_i; the user must write
// them only while no bar is in flight, which the block itself does not
// enforce.
module session_range_breakout_trader #(
  parameter int PRICE_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  srbt_bar_if.sink                        bar_i,
  srbt_res_if.source                      result_o,
  input  logic                            cfg_we_i,
  input  logic [srbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srbt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  srbt_pkg::srbt_cmd_t cmd;
  srbt_pkg::srbt_sts_t sts;
  logic                bar_ready;

  srbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bar_valid_i (bar_i.valid),
    .bar_ready_o (bar_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srbt_dp #(
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .new_day_i      (bar_i.new_day),
    .hour_i         (bar_i.hour),
    .bid_price_i    (bar_i.bid_price),
    .ask_price_i    (bar_i.ask_price),
    .res_valid_o    (result_o.valid),
    .res_ready_i    (result_o.ready),
    .pnl_centi_bp_o (result_o.pnl_centi_bp),
    .went_long_o    (result_o.went_long),
    .exit_cause_o   (result_o.exit_cause),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  assign bar_i.ready = bar_ready;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the session range breakout trader: bar driver, result monitor.
module testbench;
  import srbt_pkg::*;

  localparam int     PRICE_BITS  = 24;
  localparam int     PRICE_TOP   = (1 << PRICE_BITS) - 1;
  localparam int     RST_CYCLES  = 7;
  localparam int     SETTLE      = 40;      // longest bar is an exit with divide
  localparam int     LONG_HOLD   = 400;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam longint RET_CAP     = 1000000;

  typedef struct {
    bit                    new_day;
    logic [HOUR_W-1:0]     hour;
    logic [PRICE_BITS-1:0] bid;
    logic [PRICE_BITS-1:0] ask;
  } bar_t;

  typedef struct {
    logic signed [PNL_W-1:0] pnl;
    bit                      went_long;
    srbt_cause_e             cause;
  } trade_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  srbt_bar_if #(.PRICE_BITS(PRICE_BITS)) bar_ch ();
  srbt_res_if res_ch ();

  session_range_breakout_trader #(.PRICE_BITS(PRICE_BITS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bar_i       (bar_ch),
    .result_o    (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the registers
  logic [BUF_W-1:0]    cfg_buffer     = BUFFER_PERCENT_RST;
  logic [TENTHS_W-1:0] cfg_tenths     = TARGET_TENTHS_RST;
  logic [LIMIT_W-1:0]  cfg_limit      = COMPRESS_LIMIT_RST;
  logic [HOUR_W-1:0]   cfg_range_end  = RANGE_END_HOUR_RST;
  logic [HOUR_W-1:0]   cfg_entry_end  = ENTRY_END_HOUR_RST;
  logic [HOUR_W-1:0]   cfg_exit_hour  = EXIT_HOUR_RST;

  // Day book of the trading predictor
  logic [PRICE_BITS:0]   rng_hi2, rng_lo2, stop2;
  logic [PRICE_BITS-1:0] entry_px;
  bit                    rng_seen, pos_open, pos_long, day_traded;
  longint                target20;

  bar_t   bars_pending[$];
  bar_t   bar_held;
  trade_t trades_due[$];
  trade_t trade_front;
  int     bars_queued, bars_taken, trades_booked, mismatches;
  int     tx_idle_pct, rx_idle_pct;
  int     hold_asks, hold_given, hold_left;
  int     cycle_count;

  function automatic void reset_day_book();
    rng_hi2    = '0;
    rng_lo2    = '1;
    rng_seen   = 1'b0;
    pos_open   = 1'b0;
    pos_long   = 1'b0;
    day_traded = 1'b0;
    entry_px   = '0;
    stop2      = '0;
    target20   = 0;
  endfunction

  // Apply one accepted bar to the day book; queue the trade it closes, if any
  function automatic void book_bar(input bar_t b);
    longint bid, ask, mid2, hi2, lo2, rng2, cut, diff, ret;
    bit     hit;
    trade_t t;
    bid = b.bid;
    ask = b.ask;
    if (b.new_day) reset_day_book();
    if (ask <= bid) return;
    mid2 = bid + ask;

    // Open position: stop first, then target, then the clock
    if (pos_open) begin
      hit = 1'b1;
      t.went_long = pos_long;
      t.cause = CAUSE_STOP;
      if (pos_long ? (2 * bid <= longint'(stop2)) : (2 * ask >= longint'(stop2))) begin
        t.cause = CAUSE_STOP;
      end else if (pos_long ? (20 * bid >= target20) : (20 * ask <= target20)) begin
        t.cause = CAUSE_TARGET;
      end else if (b.hour >= cfg_exit_hour) begin
        t.cause = CAUSE_TIME;
      end else begin
        hit = 1'b0;
      end
      if (!hit) return;
      diff = pos_long ? bid - longint'(entry_px) : longint'(entry_px) - ask;
      if (entry_px == 0) begin
        ret = (diff > 0) ? RET_CAP : ((diff < 0) ? -RET_CAP : 0);
      end else begin
        ret = diff * 1000000 / longint'(entry_px);
        if (ret > RET_CAP) ret = RET_CAP;
        if (ret < -RET_CAP) ret = -RET_CAP;
      end
      t.pnl = ret[PNL_W-1:0];
      trades_due.insert(trades_due.size(), t);
      trades_booked++;
      pos_open   = 1'b0;
      day_traded = 1'b1;
      return;
    end

    // Early hours widen the range
    if (b.hour < cfg_range_end) begin
      if (mid2 > longint'(rng_hi2)) rng_hi2 = mid2[PRICE_BITS:0];
      if (mid2 < longint'(rng_lo2)) rng_lo2 = mid2[PRICE_BITS:0];
      rng_seen = 1'b1;
      return;
    end

    // Breakout test inside the entry window
    if (day_traded || !rng_seen || b.hour >= cfg_entry_end || rng_hi2 <= rng_lo2) return;
    hi2  = rng_hi2;
    lo2  = rng_lo2;
    rng2 = hi2 - lo2;
    cut  = rng2 * longint'(cfg_buffer);
    if (rng2 * 10000 > longint'(cfg_limit) * lo2) return;
    if (mid2 * 100 > hi2 * 100 + cut) begin
      pos_open = 1'b1;
      pos_long = 1'b1;
      entry_px = b.ask;
      stop2    = rng_lo2;
      target20 = ask * 20 + longint'(cfg_tenths) * rng2;
    end else if (mid2 * 100 < lo2 * 100 - cut) begin
      pos_open = 1'b1;
      pos_long = 1'b0;
      entry_px = b.bid;
      stop2    = rng_hi2;
      target20 = bid * 20 - longint'(cfg_tenths) * rng2;
    end
  endfunction

  // Bar driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      bar_ch.valid <= 1'b0;
    end else if (!bar_ch.valid || bar_ch.ready) begin
      if (bar_ch.valid) begin
        book_bar(bar_held);
        bars_taken++;
      end
      if (bars_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        bar_held = bars_pending.pop_front();
        bar_ch.valid     <= 1'b1;
        bar_ch.new_day   <= bar_held.new_day;
        bar_ch.hour      <= bar_held.hour;
        bar_ch.bid_price <= bar_held.bid;
        bar_ch.ask_price <= bar_held.ask;
      end else begin
        bar_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_given != hold_asks) begin
      res_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      hold_given   <= hold_given + 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (trades_due.size() == 0) begin
        mismatches++;
        $display("%0t: trade result with none pending: pnl %0d long %0b cause %0d",
                 $time, res_ch.pnl_centi_bp, res_ch.went_long, res_ch.exit_cause);
      end else begin
        trade_front = trades_due.pop_front();
        if (res_ch.pnl_centi_bp !== trade_front.pnl) begin
          mismatches++;
          $display("%0t: pnl_centi_bp expected %0d, got %0d",
                   $time, trade_front.pnl, res_ch.pnl_centi_bp);
        end
        if (res_ch.went_long !== trade_front.went_long) begin
          mismatches++;
          $display("%0t: went_long expected %0b, got %0b",
                   $time, trade_front.went_long, res_ch.went_long);
        end
        if (res_ch.exit_cause !== trade_front.cause) begin
          mismatches++;
          $display("%0t: exit_cause expected %0d, got %0d",
                   $time, trade_front.cause, res_ch.exit_cause);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_bar(input bit nd, input int h, input int bid, input int ask);
    bar_t b;
    b.new_day = nd;
    b.hour    = h[HOUR_W-1:0];
    b.bid     = bid[PRICE_BITS-1:0];
    b.ask     = ask[PRICE_BITS-1:0];
    bars_pending.insert(bars_pending.size(), b);
    bars_queued++;
  endtask

  // One quote around mid; now and then a crossed or locked quote
  task automatic queue_quote(input bit nd, input int h, inout int mid, input int sprd);
    int bid, ask, lim;
    if (mid < 0) mid = 0;
    if (mid > PRICE_TOP - sprd) mid = PRICE_TOP - sprd;
    bid = mid;
    ask = mid + sprd;
    if ($urandom_range(99) < 4) begin
      lim = (bid < 50) ? bid : 50;
      ask = bid - int'($urandom_range(lim));
    end
    queue_bar(nd, h, bid, ask);
  endtask

  function automatic int step_hour(input int h, input int lo, input int hi);
    int nh;
    nh = (h < lo) ? lo : h + int'($urandom_range(1));
    if (nh > hi) nh = hi;
    return nh;
  endfunction

  task automatic write_reg(input srbt_cfg_idx_e idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_BUFFER_PERCENT:    cfg_buffer    = data[BUF_W-1:0];
      CFG_TARGET_TENTHS:     cfg_tenths    = data[TENTHS_W-1:0];
      CFG_COMPRESS_LIMIT_BP: cfg_limit     = data[LIMIT_W-1:0];
      CFG_RANGE_END_HOUR:    cfg_range_end = data[HOUR_W-1:0];
      CFG_ENTRY_END_HOUR:    cfg_entry_end = data[HOUR_W-1:0];
      CFG_EXIT_HOUR:         cfg_exit_hour = data[HOUR_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every bar is taken and every trade is back, then let the block go quiet
  task automatic settle();
    do @(negedge clk_i);
    while (bars_pending.size() != 0 || bars_taken != bars_queued || trades_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random trading days: mostly well-formed sessions, some noise
  task automatic run_days(input int n_bars, input int n_trades);
    int first_bar, first_trade, mid, sprd, step, h, n, dir, lo, hi;
    bit nd;
    first_bar   = bars_queued;
    first_trade = trades_booked;
    while ((bars_queued - first_bar < n_bars || trades_booked - first_trade < n_trades) &&
           bars_queued - first_bar < 4 * n_bars) begin
      if ($urandom_range(99) < 8) begin
        repeat (6) queue_bar($urandom_range(1), $urandom_range(31), $urandom(), $urandom());
      end else begin
        mid  = $urandom_range(PRICE_TOP - 2000, 2000);
        if ($urandom_range(9) == 0) mid = $urandom_range(5000, 50);
        sprd = $urandom_range(40, 1);
        step = int'(longint'(mid) * $urandom_range(250, 5) / 1000000) + 1;
        nd   = ($urandom_range(9) != 0);
        h    = 0;
        // opening range
        if (cfg_range_end != 0) begin
          n = $urandom_range(5, 1);
          repeat (n) begin
            h = step_hour(h, 0, int'(cfg_range_end) - 1);
            mid += int'($urandom_range(2 * step)) - step;
            queue_quote(nd, h, mid, sprd);
            nd = 1'b0;
          end
        end
        // entry window: drift one way
        dir = $urandom_range(1) ? 1 : -1;
        if (cfg_entry_end > cfg_range_end) begin
          n = $urandom_range(4, 1);
          repeat (n) begin
            h = step_hour(h, int'(cfg_range_end), int'(cfg_entry_end) - 1);
            mid += dir * step * int'($urandom_range(4));
            queue_quote(nd, h, mid, sprd);
            nd = 1'b0;
          end
        end
        // rest of the day: wander toward stop, target or the close
        lo = (cfg_entry_end > cfg_range_end) ? int'(cfg_entry_end) : int'(cfg_range_end);
        hi = ($urandom_range(7) == 0) ? 31 : 23;
        if (lo > hi) hi = 31;
        n = $urandom_range(6, 1);
        repeat (n) begin
          h = step_hour(h, lo, hi);
          mid += int'($urandom_range(6 * step)) - 3 * step;
          queue_quote(nd, h, mid, sprd);
          nd = 1'b0;
        end
      end
      while (bars_pending.size() > 24) @(negedge clk_i);
    end
  endtask

  // Stimulus
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_BUFFER_PERCENT;
    cfg_data_i       = '0;
    bar_ch.valid     = 1'b0;
    bar_ch.new_day   = 1'b0;
    bar_ch.hour      = '0;
    bar_ch.bid_price = '0;
    bar_ch.ask_price = '0;
    res_ch.ready     = 1'b0;
    tx_idle_pct      = 12;
    rx_idle_pct      = 49;
    reset_day_book();
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: long win on target, day already traded
    queue_bar(1, 0, 1000000, 1000010);
    queue_bar(0, 3, 1000100, 1000110);
    queue_bar(0, 8, 5, 5);
    queue_bar(0, 8, PRICE_TOP, 0);
    queue_bar(0, 8, 1000200, 1000210);
    queue_bar(0, 9, 1000500, 1000510);
    queue_bar(0, 10, 900000, 900010);
    // short stopped out
    queue_bar(1, 1, 2000000, 2000020);
    queue_bar(0, 2, 2000100, 2000120);
    queue_bar(0, 7, 1999800, 1999820);
    queue_bar(0, 8, 2000100, 2000115);
    // long at the top of the price field, time exit at hour 31
    queue_bar(1, 0, 16777000, 16777100);
    queue_bar(0, 1, 16777050, 16777150);
    queue_bar(0, 7, 16777200, PRICE_TOP);
    queue_bar(0, 15, 16777100, 16777110);
    queue_bar(0, 31, 16777210, PRICE_TOP);
    // open position dropped by a new day
    queue_bar(1, 0, 3000000, 3000030);
    queue_bar(0, 4, 3000060, 3000090);
    queue_bar(0, 9, 3000400, 3000430);
    queue_bar(1, 0, 3000000, 3000010);
    queue_bar(0, 23, 3000000, 3000020);
    @(negedge clk_i);
    hold_asks++;
    run_days(150, 8);
    settle();

    // Widest compression limit: zero entry price, saturated returns
    write_reg(CFG_COMPRESS_LIMIT_BP, 16383);
    queue_bar(1, 0, 1, 3);
    queue_bar(0, 1, 2, 4);
    queue_bar(0, 7, 0, 3);
    queue_bar(0, 22, 0, 2);
    queue_bar(1, 0, 100, 102);
    queue_bar(0, 1, 101, 103);
    queue_bar(0, 7, 150, 152);
    queue_bar(0, 8, 16000000, 16000001);
    queue_bar(1, 0, 100, 102);
    queue_bar(0, 1, 101, 103);
    queue_bar(0, 7, 50, 52);
    queue_bar(0, 8, 16000000, PRICE_TOP);
    run_days(130, 8);
    settle();

    // Tight setup: no buffer, smallest nonzero target and limit, short session
    write_reg(CFG_BUFFER_PERCENT, 0);
    write_reg(CFG_TARGET_TENTHS, 1);
    write_reg(CFG_COMPRESS_LIMIT_BP, 1);
    write_reg(CFG_RANGE_END_HOUR, 2);
    write_reg(CFG_ENTRY_END_HOUR, 5);
    write_reg(CFG_EXIT_HOUR, 9);
    run_days(120, 4);
    settle();

    // Wide setup, sender now idles more than the receiver
    tx_idle_pct = 49;
    rx_idle_pct = 12;
    write_reg(CFG_BUFFER_PERCENT, 100);
    write_reg(CFG_TARGET_TENTHS, 100);
    write_reg(CFG_COMPRESS_LIMIT_BP, 10000);
    write_reg(CFG_RANGE_END_HOUR, 10);
    write_reg(CFG_ENTRY_END_HOUR, 16);
    write_reg(CFG_EXIT_HOUR, 23);
    @(negedge clk_i);
    hold_asks++;
    run_days(150, 8);
    settle();

    // Zero compression limit never trades; hours past 23
    write_reg(CFG_BUFFER_PERCENT, 127);
    write_reg(CFG_TARGET_TENTHS, 0);
    write_reg(CFG_COMPRESS_LIMIT_BP, 0);
    write_reg(CFG_RANGE_END_HOUR, 31);
    write_reg(CFG_ENTRY_END_HOUR, 0);
    write_reg(CFG_EXIT_HOUR, 0);
    run_days(60, 0);
    settle();

    // Target at the entry price, entry window running past midnight; no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_BUFFER_PERCENT, 5);
    write_reg(CFG_COMPRESS_LIMIT_BP, 500);
    write_reg(CFG_RANGE_END_HOUR, 6);
    write_reg(CFG_ENTRY_END_HOUR, 30);
    write_reg(CFG_EXIT_HOUR, 24);
    run_days(120, 8);
    settle();

    // Buffer write with upper data bits set, widest target
    write_reg(CFG_BUFFER_PERCENT, 14'h3F94);
    write_reg(CFG_TARGET_TENTHS, 127);
    write_reg(CFG_COMPRESS_LIMIT_BP, 40);
    write_reg(CFG_RANGE_END_HOUR, 7);
    write_reg(CFG_ENTRY_END_HOUR, 12);
    write_reg(CFG_EXIT_HOUR, 21);
    run_days(120, 8);
    settle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/srbt_pkg.sv
sv/srbt_if.sv
sv/srbt_ctrl.sv
sv/srbt_dp.sv
sv/session_range_breakout_trader.sv
dv/testbench.sv
